[src/mag_comp_pkg.sv]
`default_nettype none

package mag_comp_pkg;

    // datapath widths, sized from the worst case over all resolutions
    localparam int W_RAW   = 16;  // raw reading
    localparam int W_MAG   = 16;  // |raw - offset|
    localparam int W_N     = 26;  // |raw - offset| * 1000
    localparam int W_Q     = 21;  // per-axis quotient magnitude
    localparam int W_ZR    = 21;  // Z reciprocal
    localparam int W_PZ    = W_N + W_ZR;
    localparam int W_RZ    = 12;  // Z remainder, below twice the divisor
    localparam int W_DZ    = 11;  // Z divisor
    localparam int W_T     = W_Q + 1;
    localparam int W_V     = 23;  // combined axis value, signed
    localparam int W_AV    = W_V - 1;
    localparam int W_K     = 15;  // trim coefficient
    localparam int W_PROD  = W_AV + W_K;
    localparam int W_N2    = 32;  // trimmed product after the pre-shift
    localparam int W_RECIP = 23;  // trim divisor reciprocal
    localparam int W_P2    = W_N2 + W_RECIP;
    localparam int W_Q2    = 22;
    localparam int W_R2    = 11;  // remainder, below twice the divisor
    localparam int W_D2    = 10;
    localparam int W_CFG   = 6;
    localparam int W_IDX   = 2;

    typedef enum logic [1:0] {
        FUNC_X   = 2'd0,
        FUNC_Y   = 2'd1,
        FUNC_Z   = 2'd2,
        FUNC_BAD = 2'd3
    } t_func;

    localparam logic [W_IDX-1:0] CFG_RESOLUTION = 2'd0;
    localparam logic [W_IDX-1:0] CFG_Y_TRIM     = 2'd1;
    localparam logic [W_IDX-1:0] CFG_Z_TRIM     = 2'd2;

    localparam logic [1:0] RES_16_SLOW = 2'd0;
    localparam logic [1:0] RES_16_FAST = 2'd1;
    localparam logic [1:0] RES_14      = 2'd2;
    localparam logic [1:0] RES_12      = 2'd3;

    localparam int unsigned SCALE = 1000;

    // Z axis division: q0 = (n * floor(2^26 / d)) >> 26 is q or q - 1
    localparam int Z_RECIP_SHIFT = 26;
    localparam int unsigned ZR_16_SLOW = (32'd1 << Z_RECIP_SHIFT) / 1024;
    localparam int unsigned ZR_16_FAST = (32'd1 << Z_RECIP_SHIFT) / 770;
    localparam int unsigned ZR_14      = (32'd1 << Z_RECIP_SHIFT) / 193;
    localparam int unsigned ZR_12      = (32'd1 << Z_RECIP_SHIFT) / 48;

    // trim division: /1000 = >>3 then /125, /10000 = >>4 then /625
    localparam int Y_PRE_SHIFT   = 3;
    localparam int Y_DIV         = 125;
    localparam int Y_RECIP_SHIFT = 29;
    localparam longint unsigned Y_RECIP = (64'd1 << Y_RECIP_SHIFT) / Y_DIV;
    localparam int Z_PRE_SHIFT   = 4;
    localparam int Z_DIV         = 625;
    localparam int Z_RECIP_SHIFT2 = 32;
    localparam longint unsigned Z_RECIP = (64'd1 << Z_RECIP_SHIFT2) / Z_DIV;

    function automatic logic [W_RAW-1:0] res_offset(input logic [1:0] res);
        logic [W_RAW-1:0] off;
        case (res)
            RES_16_SLOW, RES_16_FAST: off = 16'd32768;
            RES_14:                   off = 16'd8192;
            default:                  off = 16'd2048;
        endcase
        return off;
    endfunction

    // X and Y sensitivities are powers of two
    function automatic logic [3:0] res_xy_shift(input logic [1:0] res);
        logic [3:0] sh;
        case (res)
            RES_16_SLOW, RES_16_FAST: sh = 4'd10;
            RES_14:                   sh = 4'd8;
            default:                  sh = 4'd6;
        endcase
        return sh;
    endfunction

    function automatic logic [W_DZ-1:0] res_z_div(input logic [1:0] res);
        logic [W_DZ-1:0] d;
        case (res)
            RES_16_SLOW: d = 11'd1024;
            RES_16_FAST: d = 11'd770;
            RES_14:      d = 11'd193;
            default:     d = 11'd48;
        endcase
        return d;
    endfunction

    function automatic logic [W_ZR-1:0] res_z_recip(input logic [1:0] res);
        logic [W_ZR-1:0] m;
        case (res)
            RES_16_SLOW: m = W_ZR'(ZR_16_SLOW);
            RES_16_FAST: m = W_ZR'(ZR_16_FAST);
            RES_14:      m = W_ZR'(ZR_14);
            default:     m = W_ZR'(ZR_12);
        endcase
        return m;
    endfunction

    // codes 32..63 stand for 32 - c
    function automatic int trim_value(input logic [W_CFG-1:0] code);
        int t;
        t = code[W_CFG-1] ? (32 - int'(code)) : int'(code);
        return t;
    endfunction

    function automatic logic [W_K-1:0] coef_y(input logic [W_CFG-1:0] code);
        int k;
        k = 1000 + 6 * trim_value(code);
        return W_K'(k);
    endfunction

    function automatic logic [W_K-1:0] coef_z(input logic [W_CFG-1:0] code);
        int k;
        k = 13500 + 81 * trim_value(code);
        return W_K'(k);
    endfunction

endpackage

`default_nettype wire

[src/magnetometer_axis_compensation.sv]
// Magnetometer axis compensation.
// Command channel: a reading (i_func, i_raw_x/y/z) is taken at each rising
// edge with start high and busy low. busy stays low, so a reading may be
// started in every cycle.
// Result channel: o_valid is high for one cycle with o_field_mgauss
// (signed milligauss) and o_bad_axis; the receiver has no way to hold it.
// Pipeline: the result passes through a 12-register pipeline (input register,
// offset, scale by 1000, sensitivity divide, Z estimate and remainder, Z
// correction and sign, axis combine, trim coefficient, trim multiply, trim
// reciprocal, estimate and remainder, correction and output).
// Throughput: one reading per cycle, set by the fully pipelined datapath.
// Configuration: i_cfg_we writes i_cfg_wdata into the register at
// i_cfg_idx (0 resolution, 1 Y trim code, 2 Z trim code); write only while
// no reading is in flight. Other indexes are ignored.
// Reset (i_rst_n low, synchronous) clears the pipeline valid bits and sets
// all three configuration registers to 0; readings in flight are dropped.
`default_nettype none

module magnetometer_axis_compensation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [15:0] i_raw_x,
    input  wire logic [15:0] i_raw_y,
    input  wire logic [15:0] i_raw_z,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [5:0]  i_cfg_wdata,
    output logic             o_valid,
    output logic [22:0]      o_field_mgauss,
    output logic             o_bad_axis
);

    localparam int NS = 12;

    typedef mag_comp_pkg::t_func t_func;

    // configuration
    logic [1:0]                        r_resolution;
    logic [mag_comp_pkg::W_CFG-1:0]    r_y_trim;
    logic [mag_comp_pkg::W_CFG-1:0]    r_z_trim;

    // valid bits and selector of each stage
    logic [NS-1:0] r_vld;
    t_func         r_func [NS];

    logic [mag_comp_pkg::W_RAW-1:0]  r_s0_raw [3];
    logic [mag_comp_pkg::W_MAG-1:0]  r_s1_mag [3];
    logic [2:0]                      r_s1_neg;
    logic [mag_comp_pkg::W_N-1:0]    r_s2_n [3];
    logic [2:0]                      r_s2_neg;
    logic [mag_comp_pkg::W_Q-1:0]    r_s3_qx, r_s3_qy;
    logic [mag_comp_pkg::W_PZ-1:0]   r_s3_pz;
    logic [mag_comp_pkg::W_N-1:0]    r_s3_nz;
    logic [2:0]                      r_s3_neg;
    logic [mag_comp_pkg::W_Q-1:0]    r_s4_qx, r_s4_qy, r_s4_qz;
    logic [mag_comp_pkg::W_RZ-1:0]   r_s4_rz;
    logic [2:0]                      r_s4_neg;
    logic signed [mag_comp_pkg::W_T-1:0] r_s5_t [3];
    logic signed [mag_comp_pkg::W_V-1:0] r_s6_v;
    logic [mag_comp_pkg::W_AV-1:0]   r_s7_av;
    logic [mag_comp_pkg::W_K-1:0]    r_s7_k;
    logic                            r_s7_neg;
    logic signed [mag_comp_pkg::W_V-1:0] r_s7_v;
    logic [mag_comp_pkg::W_PROD-1:0] r_s8_prod;
    logic                            r_s8_neg;
    logic signed [mag_comp_pkg::W_V-1:0] r_s8_v;
    logic [mag_comp_pkg::W_N2-1:0]   r_s9_n2;
    logic [mag_comp_pkg::W_P2-1:0]   r_s9_p;
    logic                            r_s9_neg;
    logic signed [mag_comp_pkg::W_V-1:0] r_s9_v;
    logic [mag_comp_pkg::W_Q2-1:0]   r_s10_q0;
    logic [mag_comp_pkg::W_R2-1:0]   r_s10_r;
    logic                            r_s10_neg;
    logic signed [mag_comp_pkg::W_V-1:0] r_s10_v;
    logic signed [mag_comp_pkg::W_V-1:0] r_s11_field;
    logic                            r_s11_bad;

    // next values
    logic [mag_comp_pkg::W_MAG-1:0]  n_s1_mag [3];
    logic [2:0]                      n_s1_neg;
    logic signed [mag_comp_pkg::W_RAW:0] n_diff [3];
    logic [mag_comp_pkg::W_Q-1:0]    n_s4_qz0;
    logic [mag_comp_pkg::W_N-1:0]    n_s4_rem;
    logic [mag_comp_pkg::W_Q-1:0]    n_s5_q [3];
    logic signed [mag_comp_pkg::W_V-1:0] n_s6_v;
    logic [mag_comp_pkg::W_N2-1:0]   n_s9_n2;
    logic [mag_comp_pkg::W_Q2-1:0]   n_s10_q0;
    logic [mag_comp_pkg::W_N2-1:0]   n_s10_rem;
    logic [mag_comp_pkg::W_Q2-1:0]   n_s11_q;
    logic [mag_comp_pkg::W_D2-1:0]   n_div2;
    logic signed [mag_comp_pkg::W_V-1:0] n_s11_field;

    logic [mag_comp_pkg::W_RAW-1:0]  n_offset;
    logic [3:0]                      n_xy_shift;
    logic [mag_comp_pkg::W_DZ-1:0]   n_z_div;
    logic [mag_comp_pkg::W_ZR-1:0]   n_z_recip;

    assign busy = 1'b0;

    assign n_offset   = mag_comp_pkg::res_offset(r_resolution);
    assign n_xy_shift = mag_comp_pkg::res_xy_shift(r_resolution);
    assign n_z_div    = mag_comp_pkg::res_z_div(r_resolution);
    assign n_z_recip  = mag_comp_pkg::res_z_recip(r_resolution);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resolution <= mag_comp_pkg::RES_16_SLOW;
            r_y_trim     <= '0;
            r_z_trim     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mag_comp_pkg::CFG_RESOLUTION: r_resolution <= i_cfg_wdata[1:0];
                mag_comp_pkg::CFG_Y_TRIM:     r_y_trim     <= i_cfg_wdata;
                mag_comp_pkg::CFG_Z_TRIM:     r_z_trim     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NS-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_func[0] <= t_func'(i_func);
        for (int s = 1; s < NS; s++) begin
            r_func[s] <= r_func[s-1];
        end
    end

    // stage 1: magnitude of raw - offset
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_diff[a]   = $signed({1'b0, r_s0_raw[a]}) - $signed({1'b0, n_offset});
            n_s1_neg[a] = n_diff[a][mag_comp_pkg::W_RAW];
            n_s1_mag[a] = n_s1_neg[a] ? mag_comp_pkg::W_MAG'(-n_diff[a])
                                      : mag_comp_pkg::W_MAG'(n_diff[a]);
        end
    end

    // stage 4: Z quotient estimate and remainder
    always_comb begin
        n_s4_qz0 = mag_comp_pkg::W_Q'(r_s3_pz >> mag_comp_pkg::Z_RECIP_SHIFT);
        n_s4_rem = r_s3_nz - mag_comp_pkg::W_N'(n_s4_qz0) * mag_comp_pkg::W_N'(n_z_div);
    end

    // stage 5: Z correction, signs back on
    always_comb begin
        n_s5_q[0] = r_s4_qx;
        n_s5_q[1] = r_s4_qy;
        n_s5_q[2] = r_s4_qz
                  + mag_comp_pkg::W_Q'(r_s4_rz >= mag_comp_pkg::W_RZ'(n_z_div));
    end

    // stage 6: axis combine
    always_comb begin
        case (r_func[5])
            mag_comp_pkg::FUNC_X: n_s6_v = mag_comp_pkg::W_V'(r_s5_t[0]);
            mag_comp_pkg::FUNC_Y: n_s6_v = mag_comp_pkg::W_V'(r_s5_t[1])
                                         - mag_comp_pkg::W_V'(r_s5_t[2]);
            mag_comp_pkg::FUNC_Z: n_s6_v = mag_comp_pkg::W_V'(r_s5_t[1])
                                         + mag_comp_pkg::W_V'(r_s5_t[2]);
            default:              n_s6_v = '0;
        endcase
    end

    // stages 9 to 11: divide the trimmed product by 1000 or 10000
    always_comb begin
        if (r_func[8] == mag_comp_pkg::FUNC_Y) begin
            n_s9_n2 = mag_comp_pkg::W_N2'(r_s8_prod >> mag_comp_pkg::Y_PRE_SHIFT);
        end else begin
            n_s9_n2 = mag_comp_pkg::W_N2'(r_s8_prod >> mag_comp_pkg::Z_PRE_SHIFT);
        end

        if (r_func[9] == mag_comp_pkg::FUNC_Y) begin
            n_s10_q0 = mag_comp_pkg::W_Q2'(r_s9_p >> mag_comp_pkg::Y_RECIP_SHIFT);
        end else begin
            n_s10_q0 = mag_comp_pkg::W_Q2'(r_s9_p >> mag_comp_pkg::Z_RECIP_SHIFT2);
        end

        if (r_func[10] == mag_comp_pkg::FUNC_Y) begin
            n_div2 = mag_comp_pkg::W_D2'(mag_comp_pkg::Y_DIV);
        end else begin
            n_div2 = mag_comp_pkg::W_D2'(mag_comp_pkg::Z_DIV);
        end
    end

    always_comb begin
        if (r_func[9] == mag_comp_pkg::FUNC_Y) begin
            n_s10_rem = r_s9_n2 - mag_comp_pkg::W_N2'(n_s10_q0)
                                * mag_comp_pkg::W_N2'(mag_comp_pkg::Y_DIV);
        end else begin
            n_s10_rem = r_s9_n2 - mag_comp_pkg::W_N2'(n_s10_q0)
                                * mag_comp_pkg::W_N2'(mag_comp_pkg::Z_DIV);
        end
    end

    always_comb begin
        n_s11_q = r_s10_q0
                + mag_comp_pkg::W_Q2'(r_s10_r >= mag_comp_pkg::W_R2'(n_div2));
        case (r_func[10])
            mag_comp_pkg::FUNC_X: n_s11_field = r_s10_v;
            mag_comp_pkg::FUNC_Y,
            mag_comp_pkg::FUNC_Z: begin
                n_s11_field = r_s10_neg ? -$signed({1'b0, n_s11_q})
                                        :  $signed({1'b0, n_s11_q});
            end
            default:              n_s11_field = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        // stage 0: input register
        r_s0_raw[0] <= i_raw_x;
        r_s0_raw[1] <= i_raw_y;
        r_s0_raw[2] <= i_raw_z;

        // stage 1
        r_s1_mag <= n_s1_mag;
        r_s1_neg <= n_s1_neg;

        // stage 2: scale by 1000
        for (int a = 0; a < 3; a++) begin
            r_s2_n[a] <= mag_comp_pkg::W_N'(r_s1_mag[a])
                       * mag_comp_pkg::W_N'(mag_comp_pkg::SCALE);
        end
        r_s2_neg <= r_s1_neg;

        // stage 3: X, Y sensitivities are shifts; Z by reciprocal
        r_s3_qx  <= mag_comp_pkg::W_Q'(r_s2_n[0] >> n_xy_shift);
        r_s3_qy  <= mag_comp_pkg::W_Q'(r_s2_n[1] >> n_xy_shift);
        r_s3_pz  <= mag_comp_pkg::W_PZ'(r_s2_n[2]) * mag_comp_pkg::W_PZ'(n_z_recip);
        r_s3_nz  <= r_s2_n[2];
        r_s3_neg <= r_s2_neg;

        // stage 4
        r_s4_qx  <= r_s3_qx;
        r_s4_qy  <= r_s3_qy;
        r_s4_qz  <= n_s4_qz0;
        r_s4_rz  <= mag_comp_pkg::W_RZ'(n_s4_rem);
        r_s4_neg <= r_s3_neg;

        // stage 5
        for (int a = 0; a < 3; a++) begin
            r_s5_t[a] <= r_s4_neg[a] ? -$signed({1'b0, n_s5_q[a]})
                                     :  $signed({1'b0, n_s5_q[a]});
        end

        // stage 6
        r_s6_v <= n_s6_v;

        // stage 7: magnitude and trim coefficient
        r_s7_neg <= r_s6_v[mag_comp_pkg::W_V-1];
        r_s7_av  <= r_s6_v[mag_comp_pkg::W_V-1] ? mag_comp_pkg::W_AV'(-r_s6_v)
                                                : mag_comp_pkg::W_AV'(r_s6_v);
        r_s7_k   <= (r_func[6] == mag_comp_pkg::FUNC_Y) ? mag_comp_pkg::coef_y(r_y_trim)
                                                        : mag_comp_pkg::coef_z(r_z_trim);
        r_s7_v   <= r_s6_v;

        // stage 8: trim multiply
        r_s8_prod <= mag_comp_pkg::W_PROD'(r_s7_av) * mag_comp_pkg::W_PROD'(r_s7_k);
        r_s8_neg  <= r_s7_neg;
        r_s8_v    <= r_s7_v;

        // stage 9: reciprocal multiply
        r_s9_n2  <= n_s9_n2;
        r_s9_p   <= (r_func[8] == mag_comp_pkg::FUNC_Y)
                  ? mag_comp_pkg::W_P2'(n_s9_n2) * mag_comp_pkg::W_P2'(mag_comp_pkg::Y_RECIP)
                  : mag_comp_pkg::W_P2'(n_s9_n2) * mag_comp_pkg::W_P2'(mag_comp_pkg::Z_RECIP);
        r_s9_neg <= r_s8_neg;
        r_s9_v   <= r_s8_v;

        // stage 10: estimate and remainder
        r_s10_q0  <= n_s10_q0;
        r_s10_r   <= mag_comp_pkg::W_R2'(n_s10_rem);
        r_s10_neg <= r_s9_neg;
        r_s10_v   <= r_s9_v;

        // stage 11: output register
        r_s11_field <= n_s11_field;
        r_s11_bad   <= (r_func[10] == mag_comp_pkg::FUNC_BAD);
    end

    assign o_valid        = r_vld[NS-1];
    assign o_field_mgauss = r_s11_field;
    assign o_bad_axis     = r_s11_bad;

endmodule

`default_nettype wire

[tb/magnetometer_axis_compensation_tb.sv]
module magnetometer_axis_compensation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef mag_comp_pkg::t_func t_func;

    localparam t_func FUNC_X   = mag_comp_pkg::FUNC_X;
    localparam t_func FUNC_Y   = mag_comp_pkg::FUNC_Y;
    localparam t_func FUNC_Z   = mag_comp_pkg::FUNC_Z;
    localparam t_func FUNC_BAD = mag_comp_pkg::FUNC_BAD;

    localparam logic [1:0] RES_16_SLOW = mag_comp_pkg::RES_16_SLOW;
    localparam logic [1:0] RES_16_FAST = mag_comp_pkg::RES_16_FAST;
    localparam logic [1:0] RES_14      = mag_comp_pkg::RES_14;
    localparam logic [1:0] RES_12      = mag_comp_pkg::RES_12;

    localparam logic [mag_comp_pkg::W_IDX-1:0] CFG_RESOLUTION = mag_comp_pkg::CFG_RESOLUTION;
    localparam logic [mag_comp_pkg::W_IDX-1:0] CFG_Y_TRIM     = mag_comp_pkg::CFG_Y_TRIM;
    localparam logic [mag_comp_pkg::W_IDX-1:0] CFG_Z_TRIM     = mag_comp_pkg::CFG_Z_TRIM;
    localparam logic [mag_comp_pkg::W_IDX-1:0] CFG_UNUSED     = 2'd3;

    localparam int PIPE_LAT    = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_PHASES    = 13;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        logic [22:0] field;
        logic        bad;
    } t_reading;

    typedef struct packed {
        logic [1:0]  res;
        logic [5:0]  ytc;
        logic [5:0]  ztc;
        t_func       func;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        typed;
        logic [22:0] field;
        logic        bad;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_func;
    logic [15:0] i_raw_x;
    logic [15:0] i_raw_y;
    logic [15:0] i_raw_z;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [5:0]  i_cfg_wdata;
    logic        o_valid;
    logic [22:0] o_field_mgauss;
    logic        o_bad_axis;

    // typed-in expectation that travels with the transaction
    logic        row_typed;
    logic [22:0] row_field;
    logic        row_bad;

    t_reading pending_readings[$];
    t_dir_row dir_rows[$];

    // register values as seen by the block, tracked at the write edges
    logic [1:0] shadow_res;
    logic [5:0] shadow_ytc;
    logic [5:0] shadow_ztc;
    // driver's own view, used to pick stimulus
    logic [1:0] cur_res;
    logic [5:0] cur_ytc;
    logic [5:0] cur_ztc;

    int errors = 0;
    int cycles = 0;

    magnetometer_axis_compensation DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_raw_x        (i_raw_x),
        .i_raw_y        (i_raw_y),
        .i_raw_z        (i_raw_z),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_field_mgauss (o_field_mgauss),
        .o_bad_axis     (o_bad_axis)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_reading compensate_reading(input t_func f, input logic [15:0] x,
                                                    input logic [15:0] y, input logic [15:0] z,
                                                    input logic [1:0] res,
                                                    input logic [5:0] ytc,
                                                    input logic [5:0] ztc);
        longint off, sx, sy, sz;
        longint tx, ty, tz, yv, zv, v;
        t_reading r;
        case (res)
            RES_16_SLOW: begin off = 32768; sx = 1024; sy = 1024; sz = 1024; end
            RES_16_FAST: begin off = 32768; sx = 1024; sy = 1024; sz = 770;  end
            RES_14:      begin off = 8192;  sx = 256;  sy = 256;  sz = 193;  end
            default:     begin off = 2048;  sx = 64;   sy = 64;   sz = 48;   end
        endcase
        // upper half of the trim code range maps to 32 - code, zero or negative
        yv = ytc[5] ? 32 - longint'(ytc) : longint'(ytc);
        zv = ztc[5] ? 32 - longint'(ztc) : longint'(ztc);
        tx = (longint'(x) - off) * 1000 / sx;
        ty = (longint'(y) - off) * 1000 / sy;
        tz = (longint'(z) - off) * 1000 / sz;
        r.bad = 1'b0;
        case (f)
            FUNC_X:  v = tx;
            FUNC_Y:  v = (ty - tz) * (1000 + 6 * yv) / 1000;
            FUNC_Z:  v = (ty + tz) * (13500 + 81 * zv) / 10000;
            default: begin
                v = 0;
                r.bad = 1'b1;
            end
        endcase
        r.field = v[22:0];
        return r;
    endfunction

    function automatic t_dir_row drow(input logic [1:0] res, input logic [5:0] ytc,
                                      input logic [5:0] ztc, input t_func f,
                                      input logic [15:0] x, input logic [15:0] y,
                                      input logic [15:0] z, input logic typed,
                                      input int field, input logic bad);
        t_dir_row r;
        r.res = res;
        r.ytc = ytc;
        r.ztc = ztc;
        r.func = f;
        r.x = x;
        r.y = y;
        r.z = z;
        r.typed = typed;
        r.field = field[22:0];
        r.bad = bad;
        return r;
    endfunction

    // readings clustered at the rails and around the null-field offset
    function automatic logic [15:0] pick_raw(input logic [1:0] res);
        logic [15:0] off;
        logic [15:0] v;
        case (res)
            RES_16_SLOW, RES_16_FAST: off = 16'd32768;
            RES_14:                   off = 16'd8192;
            default:                  off = 16'd2048;
        endcase
        case ($urandom_range(0, 9))
            0:       v = 16'h0000;
            1:       v = 16'hFFFF;
            2, 3:    v = off + 16'($urandom_range(0, 40)) - 16'd20;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic void note_mismatch(input string what, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    endfunction

    // scoreboard: predicts on every accepted command, checks every strobed result
    always @(posedge i_clk) begin : monitor
        t_reading got;
        t_reading want;
        if (i_rst_n !== 1'b1) begin
            shadow_res = RES_16_SLOW;
            shadow_ytc = '0;
            shadow_ztc = '0;
        end else begin
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_idx)
                    CFG_RESOLUTION: shadow_res = i_cfg_wdata[1:0];
                    CFG_Y_TRIM:     shadow_ytc = i_cfg_wdata;
                    CFG_Z_TRIM:     shadow_ztc = i_cfg_wdata;
                    default:        ;
                endcase
            end
            if (start === 1'b1 && busy === 1'b0) begin
                if (row_typed)
                    pending_readings.push_back({row_field, row_bad});
                else
                    pending_readings.push_back(compensate_reading(t_func'(i_func), i_raw_x,
                        i_raw_y, i_raw_z, shadow_res, shadow_ytc, shadow_ztc));
            end
            if (o_valid === 1'b1) begin
                got = {o_field_mgauss, o_bad_axis};
                if (pending_readings.size() == 0) begin
                    note_mismatch("unexpected result, field", 0, $signed(got.field));
                end else begin
                    want = pending_readings.pop_front();
                    if (got.field !== want.field)
                        note_mismatch("field_mgauss", $signed(want.field), $signed(got.field));
                    if (got.bad !== want.bad)
                        note_mismatch("bad_axis", want.bad, got.bad);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send(input t_func f, input logic [15:0] x, input logic [15:0] y,
                        input logic [15:0] z, input logic typed, input logic [22:0] field,
                        input logic bad);
        start     <= 1'b1;
        i_func    <= f;
        i_raw_x   <= x;
        i_raw_y   <= y;
        i_raw_z   <= z;
        row_typed <= typed;
        row_field <= field;
        row_bad   <= bad;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic maybe_idle(input int rate);
        if (rate != 0 && $urandom_range(1, rate) == 1) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // drain the pipeline before touching the registers
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [1:0] res, input logic [5:0] ytc,
                                input logic [5:0] ztc);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_RESOLUTION;
        i_cfg_wdata <= {4'($urandom_range(0, 15)), res};
        @(posedge i_clk);
        i_cfg_idx   <= CFG_Y_TRIM;
        i_cfg_wdata <= ytc;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_Z_TRIM;
        i_cfg_wdata <= ztc;
        @(posedge i_clk);
        // unmapped index must leave everything alone
        if ($urandom_range(0, 1) == 1) begin
            i_cfg_idx   <= CFG_UNUSED;
            i_cfg_wdata <= 6'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_res = res;
        cur_ytc = ytc;
        cur_ztc = ztc;
    endtask

    initial begin
        t_dir_row r;
        logic [1:0] res;
        logic [5:0] ytc;
        logic [5:0] ztc;
        int rate;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_func      <= FUNC_X;
        i_raw_x     <= '0;
        i_raw_y     <= '0;
        i_raw_z     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_RESOLUTION;
        i_cfg_wdata <= '0;
        row_typed   <= 1'b0;
        row_field   <= '0;
        row_bad     <= 1'b0;
        cur_res = RES_16_SLOW;
        cur_ytc = '0;
        cur_ztc = '0;

        // values after reset, rails, truncation toward zero, invalid selector
        dir_rows.push_back(drow(RES_16_SLOW, 0, 0, FUNC_X, 16'd32768, 0, 0, 1, 0, 0));
        dir_rows.push_back(drow(RES_16_SLOW, 0, 0, FUNC_X, 16'd0, 0, 0, 1, -32000, 0));
        dir_rows.push_back(drow(RES_16_SLOW, 0, 0, FUNC_X, 16'hFFFF, 0, 0, 1, 31999, 0));
        dir_rows.push_back(drow(RES_16_SLOW, 0, 0, FUNC_X, 16'd1, 0, 0, 1, -31999, 0));
        dir_rows.push_back(drow(RES_16_SLOW, 0, 0, FUNC_BAD, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                1, 0, 1));
        dir_rows.push_back(drow(RES_16_SLOW, 0, 0, FUNC_BAD, 0, 0, 0, 1, 0, 1));
        dir_rows.push_back(drow(RES_16_SLOW, 0, 0, FUNC_Y, 0, 16'd32768, 16'd32768, 1, 0, 0));
        dir_rows.push_back(drow(RES_16_SLOW, 0, 0, FUNC_Z, 0, 16'd32768, 16'd32768, 1, 0, 0));
        dir_rows.push_back(drow(RES_16_SLOW, 0, 0, FUNC_Y, 0, 16'hFFFF, 0, 0, 0, 0));
        dir_rows.push_back(drow(RES_16_SLOW, 0, 0, FUNC_Y, 0, 0, 16'hFFFF, 0, 0, 0));
        dir_rows.push_back(drow(RES_16_SLOW, 0, 0, FUNC_Z, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0));
        dir_rows.push_back(drow(RES_16_SLOW, 0, 0, FUNC_Z, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(RES_16_FAST, 6'd1, 6'd62, FUNC_Z, 16'hFFFF, 0, 16'hFFFF,
                                0, 0, 0));
        dir_rows.push_back(drow(RES_16_FAST, 6'd1, 6'd62, FUNC_Y, 16'hFFFF, 16'hFFFF, 0,
                                0, 0, 0));
        dir_rows.push_back(drow(RES_16_FAST, 6'd1, 6'd62, FUNC_X, 16'd12345, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(RES_14, 6'd31, 6'd31, FUNC_Y, 0, 16'hFFFF, 0, 0, 0, 0));
        dir_rows.push_back(drow(RES_14, 6'd31, 6'd31, FUNC_Z, 0, 16'hFFFF, 16'hFFFF,
                                0, 0, 0));
        dir_rows.push_back(drow(RES_14, 6'd31, 6'd31, FUNC_X, 0, 0, 0, 1, -32000, 0));
        dir_rows.push_back(drow(RES_12, 6'd32, 6'd32, FUNC_Z, 0, 16'hFFFF, 16'hFFFF,
                                0, 0, 0));
        dir_rows.push_back(drow(RES_12, 6'd32, 6'd32, FUNC_Y, 0, 0, 16'hFFFF, 0, 0, 0));
        dir_rows.push_back(drow(RES_12, 6'd32, 6'd32, FUNC_X, 16'hFFFF, 0, 0, 1, 991984, 0));
        dir_rows.push_back(drow(RES_12, 6'd63, 6'd63, FUNC_Y, 0, 16'hFFFF, 0, 0, 0, 0));
        dir_rows.push_back(drow(RES_12, 6'd63, 6'd63, FUNC_Z, 16'hFFFF, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(RES_12, 6'd33, 6'd31, FUNC_Y, 0, 0, 16'hFFFF, 0, 0, 0));
        dir_rows.push_back(drow(RES_12, 6'd33, 6'd31, FUNC_Z, 0, 16'hFFFF, 16'hFFFF,
                                0, 0, 0));
        dir_rows.push_back(drow(RES_12, 6'd33, 6'd31, FUNC_X, 16'd2048, 0, 0, 1, 0, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.res != cur_res || r.ytc != cur_ytc || r.ztc != cur_ztc)
                apply_config(r.res, r.ytc, r.ztc);
            maybe_idle(4);
            send(r.func, r.x, r.y, r.z, r.typed, r.field, r.bad);
        end

        // first phases hit the register extremes, the rest are random
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       begin res = RES_16_SLOW; ytc = 6'd0;  ztc = 6'd63; end
                1:       begin res = RES_16_FAST; ytc = 6'd31; ztc = 6'd32; end
                2:       begin res = RES_14;      ytc = 6'd32; ztc = 6'd31; end
                3:       begin res = RES_12;      ytc = 6'd63; ztc = 6'd0;  end
                default: begin
                    res = 2'($urandom_range(0, 3));
                    ytc = 6'($urandom_range(0, 63));
                    ztc = 6'($urandom_range(0, 63));
                end
            endcase
            apply_config(res, ytc, ztc);
            rate = (p >= N_PHASES - 2 || p % 3 == 2) ? 0 : 4;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                maybe_idle(rate);
                send(t_func'($urandom_range(0, 3)), pick_raw(cur_res), pick_raw(cur_res),
                     pick_raw(cur_res), 1'b0, '0, 1'b0);
            end
        end

        settle();
        if (pending_readings.size() != 0) begin
            note_mismatch("missing results, count", 0, pending_readings.size());
        end
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[magnetometer_axis_compensation.f]
src/mag_comp_pkg.sv
src/magnetometer_axis_compensation.sv
tb/magnetometer_axis_compensation_tb.sv
